FILE: rtl/bmprle_pkg.sv
`default_nettype none
package bmprle_pkg;

	typedef enum logic [2:0] {
		KIND_RUN   = 3'd0,
		KIND_EOL   = 3'd1,
		KIND_DELTA = 3'd2,
		KIND_EOB   = 3'd3,
		KIND_ERROR = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		MODE_RAW  = 2'd0,
		MODE_RLE8 = 2'd1,
		MODE_RLE4 = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [7:0] {
		PH_FIRST   = 8'b0000_0001,
		PH_VALUE   = 8'b0000_0010,
		PH_ESCAPE  = 8'b0000_0100,
		PH_DX      = 8'b0000_1000,
		PH_DY      = 8'b0001_0000,
		PH_ABS     = 8'b0010_0000,
		PH_PAD     = 8'b0100_0000,
		PH_STOPPED = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] pixel_count;
		logic [7:0] pattern;
		logic       alternate;
		logic [7:0] delta_x;
		logic [7:0] delta_y;
	} item_t;

	typedef struct packed {
		logic        we;
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_write_t;

endpackage
`default_nettype wire

FILE: rtl/bmprle_front.sv
`default_nettype none
module bmprle_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bmprle_pkg::cfg_write_t  cfg_wr,
	input  wire logic                    accept,
	input  wire logic [7:0]              data_byte,
	output logic                         push,
	output bmprle_pkg::item_t            push_item
);

	bmprle_pkg::mode_t  mode_q;
	logic [15:0]        width_q;
	logic [15:0]        height_q;
	bmprle_pkg::phase_t phase_q, phase_d;
	logic [7:0]         held_q, held_d;
	logic [7:0]         rem_q, rem_d;
	logic               pad_q, pad_d;
	logic [7:0]         dx_q, dx_d;
	logic               nib;
	logic [8:0]         half_sum;
	logic               abs_pad;
	logic [1:0]         abs_cnt;
	logic               emit;
	bmprle_pkg::item_t  item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= bmprle_pkg::MODE_RLE8;
			width_q  <= 16'd1;
			height_q <= 16'd1;
		end else if (cfg_wr.we) begin
			case (cfg_wr.index)
				bmprle_pkg::REG_MODE:   mode_q   <= bmprle_pkg::mode_t'(cfg_wr.data[1:0]);
				bmprle_pkg::REG_WIDTH:  width_q  <= cfg_wr.data;
				bmprle_pkg::REG_HEIGHT: height_q <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	assign nib      = (mode_q == bmprle_pkg::MODE_RLE4);
	assign half_sum = {1'b0, data_byte} + 9'd1;
	assign abs_pad  = nib ? half_sum[1] : data_byte[0];

	always_comb begin
		if (nib && rem_q >= 8'd2) begin
			abs_cnt = 2'd2;
		end else if (rem_q == 8'd0) begin
			abs_cnt = 2'd0;
		end else begin
			abs_cnt = 2'd1;
		end
	end

	always_comb begin
		phase_d = phase_q;
		held_d  = held_q;
		rem_d   = rem_q;
		pad_d   = pad_q;
		dx_d    = dx_q;
		emit    = 1'b0;
		item    = '{kind: bmprle_pkg::KIND_RUN, pixel_count: 8'd0, pattern: 8'd0,
			alternate: 1'b0, delta_x: 8'd0, delta_y: 8'd0};
		unique case (mode_q)
			bmprle_pkg::MODE_RAW: begin
				emit             = 1'b1;
				item.pixel_count = 8'd1;
				item.pattern     = data_byte;
			end
			bmprle_pkg::MODE_RLE8, bmprle_pkg::MODE_RLE4: begin
				unique case (phase_q)
					bmprle_pkg::PH_FIRST: begin
						if (data_byte != 8'd0) begin
							held_d  = data_byte;
							phase_d = bmprle_pkg::PH_VALUE;
						end else begin
							phase_d = bmprle_pkg::PH_ESCAPE;
						end
					end
					bmprle_pkg::PH_VALUE: begin
						phase_d          = bmprle_pkg::PH_FIRST;
						emit             = 1'b1;
						item.pixel_count = held_q;
						item.pattern     = data_byte;
						item.alternate   = nib;
					end
					bmprle_pkg::PH_ESCAPE: begin
						case (data_byte)
							8'd0: begin
								phase_d   = bmprle_pkg::PH_FIRST;
								emit      = 1'b1;
								item.kind = bmprle_pkg::KIND_EOL;
							end
							8'd1: begin
								phase_d   = bmprle_pkg::PH_STOPPED;
								emit      = 1'b1;
								item.kind = bmprle_pkg::KIND_EOB;
							end
							8'd2: phase_d = bmprle_pkg::PH_DX;
							default: begin
								rem_d   = data_byte;
								pad_d   = abs_pad;
								phase_d = bmprle_pkg::PH_ABS;
							end
						endcase
					end
					bmprle_pkg::PH_DX: begin
						dx_d    = data_byte;
						phase_d = bmprle_pkg::PH_DY;
					end
					bmprle_pkg::PH_DY: begin
						emit = 1'b1;
						if ({8'd0, dx_q} > width_q || {8'd0, data_byte} > height_q) begin
							phase_d   = bmprle_pkg::PH_STOPPED;
							item.kind = bmprle_pkg::KIND_ERROR;
						end else begin
							phase_d      = bmprle_pkg::PH_FIRST;
							item.kind    = bmprle_pkg::KIND_DELTA;
							item.delta_x = dx_q;
							item.delta_y = data_byte;
						end
					end
					bmprle_pkg::PH_ABS: begin
						rem_d = rem_q - {6'd0, abs_cnt};
						if (rem_d == 8'd0) begin
							phase_d = pad_q ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
						end
						emit             = 1'b1;
						item.pixel_count = {6'd0, abs_cnt};
						item.pattern     = data_byte;
						item.alternate   = nib;
					end
					bmprle_pkg::PH_PAD: begin
						pad_d   = 1'b0;
						phase_d = bmprle_pkg::PH_FIRST;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bmprle_pkg::PH_FIRST;
			held_q  <= 8'd0;
			rem_q   <= 8'd0;
			pad_q   <= 1'b0;
			dx_q    <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			rem_q   <= rem_d;
			pad_q   <= pad_d;
			dx_q    <= dx_d;
		end
	end

	assign push      = accept && emit;
	assign push_item = item;

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bmprle_pkg::PH_STOPPED |=> phase_q == bmprle_pkg::PH_STOPPED)
		else $error("parser left the stopped state");

	a_abs_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == bmprle_pkg::PH_ABS |-> rem_q != 8'd0)
		else $error("absolute run phase with no pixels left");

endmodule
`default_nettype wire

FILE: rtl/bmprle_queue.sv
`default_nettype none
module bmprle_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire bmprle_pkg::item_t  push_item,
	input  wire logic               pop,
	output logic                    full,
	output logic                    empty,
	output bmprle_pkg::item_t       head_item
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bmprle_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]     wr_q;
	logic [AW-1:0]     rd_q;
	logic [CW-1:0]     count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(full && push && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(empty && pop))
		else $error("queue read while empty");

endmodule
`default_nettype wire

FILE: rtl/bmprle_back.sv
`default_nettype none
module bmprle_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               empty,
	input  wire bmprle_pkg::item_t  head_item,
	input  wire logic               out_stall,
	output logic                    pop,
	output logic                    out_valid,
	output bmprle_pkg::item_t       out_item
);

	logic              valid_q;
	bmprle_pkg::item_t item_q;

	assign pop       = !empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= !empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head_item;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/bmp_rle_decoder.sv
`default_nettype none
// Channel  Direction  Handshake             Payload
// in       to block   in_valid / in_stall   data_byte
// out      from block out_valid / out_stall kind, pixel_count, pattern, alternate,
//                                           delta_x, delta_y
// cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input item is taken every cycle unless stalled; the parser state is registered.
// A result goes into the queue as its byte is taken, then on to the output register.
// in_stall rises only when the QDEPTH-entry queue is full because out_stall holds it.
// cfg_ready is always high. Reset is asynchronous and needs no clearing pass.
module bmp_rle_decoder #(
	parameter int QDEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       kind,
	output logic [7:0]       pixel_count,
	output logic [7:0]       pattern,
	output logic             alternate,
	output logic [7:0]       delta_x,
	output logic [7:0]       delta_y,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	bmprle_pkg::cfg_write_t cfg_wr;
	bmprle_pkg::item_t      push_item;
	bmprle_pkg::item_t      head_item;
	bmprle_pkg::item_t      out_item;
	logic                   accept;
	logic                   push;
	logic                   pop;
	logic                   full;
	logic                   empty;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = '{we: cfg_valid, index: cfg_index, data: cfg_data};
	assign in_stall  = full;
	assign accept    = in_valid && !full;

	bmprle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.accept    (accept),
		.data_byte (data_byte),
		.push      (push),
		.push_item (push_item)
	);

	bmprle_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.full      (full),
		.empty     (empty),
		.head_item (head_item)
	);

	bmprle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.head_item (head_item),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	assign kind        = out_item.kind;
	assign pixel_count = out_item.pixel_count;
	assign pattern     = out_item.pattern;
	assign alternate   = out_item.alternate;
	assign delta_x     = out_item.delta_x;
	assign delta_y     = out_item.delta_y;

endmodule
`default_nettype wire

FILE: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1700;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES = 120;
	localparam int PRINT_LIMIT = 40;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	typedef logic [7:0] byte_seq_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  kind;
	logic [7:0]  pixel_count;
	logic [7:0]  pattern;
	logic        alternate;
	logic [7:0]  delta_x;
	logic [7:0]  delta_y;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'h0000;

	bmp_rle_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.pixel_count(pixel_count),
		.pattern(pattern),
		.alternate(alternate),
		.delta_x(delta_x),
		.delta_y(delta_y),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Expected decoder behaviour: configuration and parser state.
	bmprle_pkg::mode_t  cur_mode;
	logic [15:0]        width_limit;
	logic [15:0]        height_limit;
	bmprle_pkg::phase_t parse_phase;
	logic [7:0]         run_count_held;
	logic [7:0]         pixels_left;
	logic               pad_due;
	logic [7:0]         dx_held;

	bmprle_pkg::item_t  expected_descriptors[$];
	byte_seq_t          stream_bytes;

	int          failures = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          gap_limit = 0;
	bit          stop_allowed = 1'b0;
	bit          hold_request = 1'b0;
	int          hold_left = 0;
	stall_style_t stall_style = STALL_NONE;
	int          style_left = 0;
	int          stall_tick = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic reset_model();
		cur_mode = bmprle_pkg::MODE_RLE8;
		width_limit = 16'd1;
		height_limit = 16'd1;
		parse_phase = bmprle_pkg::PH_FIRST;
		run_count_held = 8'd0;
		pixels_left = 8'd0;
		pad_due = 1'b0;
		dx_held = 8'd0;
	endtask

	function automatic bmprle_pkg::item_t descriptor(bmprle_pkg::kind_t k, logic [7:0] cnt,
			logic [7:0] pat, logic alt, logic [7:0] dx, logic [7:0] dy);
		bmprle_pkg::item_t d;
		d.kind = k;
		d.pixel_count = cnt;
		d.pattern = pat;
		d.alternate = alt;
		d.delta_x = dx;
		d.delta_y = dy;
		return d;
	endfunction

	function automatic bit decode_byte(input logic [7:0] b, output bmprle_pkg::item_t d);
		logic       nib;
		logic [8:0] data_bytes;
		logic [7:0] cnt;
		d = descriptor(bmprle_pkg::KIND_RUN, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
		nib = (cur_mode == bmprle_pkg::MODE_RLE4);
		if (cur_mode == bmprle_pkg::MODE_RAW) begin
			d = descriptor(bmprle_pkg::KIND_RUN, 8'd1, b, 1'b0, 8'd0, 8'd0);
			return 1'b1;
		end
		if (cur_mode == bmprle_pkg::MODE_NONE)
			return 1'b0;
		case (parse_phase)
			bmprle_pkg::PH_FIRST: begin
				if (b != 8'd0) begin
					run_count_held = b;
					parse_phase = bmprle_pkg::PH_VALUE;
				end else begin
					parse_phase = bmprle_pkg::PH_ESCAPE;
				end
				return 1'b0;
			end
			bmprle_pkg::PH_VALUE: begin
				parse_phase = bmprle_pkg::PH_FIRST;
				d = descriptor(bmprle_pkg::KIND_RUN, run_count_held, b, nib, 8'd0, 8'd0);
				return 1'b1;
			end
			bmprle_pkg::PH_ESCAPE: begin
				if (b == 8'd0) begin
					parse_phase = bmprle_pkg::PH_FIRST;
					d = descriptor(bmprle_pkg::KIND_EOL, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
					return 1'b1;
				end
				if (b == 8'd1) begin
					parse_phase = bmprle_pkg::PH_STOPPED;
					d = descriptor(bmprle_pkg::KIND_EOB, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
					return 1'b1;
				end
				if (b == 8'd2) begin
					parse_phase = bmprle_pkg::PH_DX;
					return 1'b0;
				end
				data_bytes = nib ? (({1'b0, b} + 9'd1) >> 1) : {1'b0, b};
				pixels_left = b;
				pad_due = data_bytes[0];
				parse_phase = bmprle_pkg::PH_ABS;
				return 1'b0;
			end
			bmprle_pkg::PH_DX: begin
				dx_held = b;
				parse_phase = bmprle_pkg::PH_DY;
				return 1'b0;
			end
			bmprle_pkg::PH_DY: begin
				if ({8'd0, dx_held} > width_limit || {8'd0, b} > height_limit) begin
					parse_phase = bmprle_pkg::PH_STOPPED;
					d = descriptor(bmprle_pkg::KIND_ERROR, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0);
					return 1'b1;
				end
				parse_phase = bmprle_pkg::PH_FIRST;
				d = descriptor(bmprle_pkg::KIND_DELTA, 8'd0, 8'd0, 1'b0, dx_held, b);
				return 1'b1;
			end
			bmprle_pkg::PH_ABS: begin
				cnt = (nib && pixels_left >= 8'd2) ? 8'd2 : 8'd1;
				if (pixels_left < cnt)
					cnt = pixels_left;
				pixels_left = pixels_left - cnt;
				if (pixels_left == 8'd0)
					parse_phase = pad_due ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
				d = descriptor(bmprle_pkg::KIND_RUN, cnt, b, nib, 8'd0, 8'd0);
				return 1'b1;
			end
			bmprle_pkg::PH_PAD: begin
				pad_due = 1'b0;
				parse_phase = bmprle_pkg::PH_FIRST;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Until the closing test, bytes that would stop the parser are bent into harmless ones.
	function automatic logic [7:0] avoid_stop(input logic [7:0] b);
		if (cur_mode != bmprle_pkg::MODE_RLE8 && cur_mode != bmprle_pkg::MODE_RLE4)
			return b;
		case (parse_phase)
			bmprle_pkg::PH_ESCAPE: if (b == 8'd1) return 8'd0;
			bmprle_pkg::PH_DX: if ({8'd0, b} > width_limit)
				return 8'(int'(b) % (int'(width_limit) + 1));
			bmprle_pkg::PH_DY: if ({8'd0, b} > height_limit)
				return 8'(int'(b) % (int'(height_limit) + 1));
			default: ;
		endcase
		return b;
	endfunction

	task automatic report_mismatch(input string msg);
		if (failures < PRINT_LIMIT)
			$display("mismatch at %0t ns: %s", $realtime, msg);
		failures++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
	endtask

	always @(posedge clk) begin
		bmprle_pkg::item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_descriptors.size() == 0) begin
				report_mismatch($sformatf("result of kind %0d with none outstanding", kind));
			end else begin
				want = expected_descriptors.pop_front();
				if ($isunknown({kind, pixel_count, pattern, alternate, delta_x, delta_y}))
					report_mismatch("result carries unknown bits");
				check_field("kind", kind, want.kind);
				check_field("pixel_count", pixel_count, want.pixel_count);
				check_field("pattern", pattern, want.pattern);
				check_field("alternate", alternate, want.alternate);
				check_field("delta_x", delta_x, want.delta_x);
				check_field("delta_y", delta_y, want.delta_y);
			end
		end
	end

	// The receiver changes its stall behaviour on its own schedule.
	always @(negedge clk) begin
		if (style_left == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 3));
			style_left = $urandom_range(20, 300);
		end
		style_left--;
		stall_tick++;
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			case (stall_style)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: out_stall <= ((stall_tick % 7) < 3);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	task automatic send_byte(input logic [7:0] raw);
		logic [7:0] b;
		bmprle_pkg::item_t d;
		b = stop_allowed ? raw : avoid_stop(raw);
		if (gap_limit > 0 && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, gap_limit)) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		if (decode_byte(b, d))
			expected_descriptors.insert(expected_descriptors.size(), d);
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
	endtask

	task automatic send_list(input byte_seq_t seq);
		foreach (seq[i])
			send_byte(seq[i]);
	endtask

	task automatic await_idle();
		in_valid <= 1'b0;
		while (expected_descriptors.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
		await_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bmprle_pkg::REG_MODE:   cur_mode = bmprle_pkg::mode_t'(value[1:0]);
			bmprle_pkg::REG_WIDTH:  width_limit = value;
			bmprle_pkg::REG_HEIGHT: height_limit = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_mode(input bmprle_pkg::mode_t m);
		write_register(bmprle_pkg::REG_MODE, {14'($urandom), m});
	endtask

	function automatic logic [15:0] pick_bound();
		case ($urandom_range(0, 3))
			0: return 16'd1;
			1: return 16'hffff;
			2: return 16'($urandom_range(1, 255));
			default: return 16'($urandom_range(256, 65535));
		endcase
	endfunction

	task automatic append_byte(input logic [7:0] b);
		stream_bytes.insert(stream_bytes.size(), b);
	endtask

	// Queues one well-formed sequence with random content, or a little noise.
	task automatic queue_sequence();
		int pick;
		int n;
		int nbytes;
		int reach;
		pick = $urandom_range(0, 99);
		if (cur_mode != bmprle_pkg::MODE_RLE8 && cur_mode != bmprle_pkg::MODE_RLE4) begin
			append_byte(8'($urandom));
		end else if (pick < 40) begin
			append_byte(8'($urandom_range(1, 255)));
			append_byte(8'($urandom));
		end else if (pick < 52) begin
			append_byte(8'd0);
			append_byte(8'd0);
		end else if (pick < 66) begin
			append_byte(8'd0);
			append_byte(8'd2);
			reach = (width_limit > 16'd255) ? 255 : int'(width_limit);
			append_byte(8'($urandom_range(0, reach)));
			reach = (height_limit > 16'd255) ? 255 : int'(height_limit);
			append_byte(8'($urandom_range(0, reach)));
		end else if (pick < 88) begin
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
			nbytes = (cur_mode == bmprle_pkg::MODE_RLE4) ? (n + 1) / 2 : n;
			append_byte(8'd0);
			append_byte(8'(n));
			repeat (nbytes) append_byte(8'($urandom));
			if (nbytes % 2 == 1)
				append_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 3))
				append_byte(($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom));
		end
	endtask

	task automatic test_rle8_escapes();
		gap_limit = 3;
		send_list('{8'h01, 8'h00, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h01,
			8'h00, 8'h03, 8'h12, 8'h34, 8'h56, 8'h99});
	endtask

	task automatic test_rle4_runs();
		set_mode(bmprle_pkg::MODE_RLE4);
		send_list('{8'h00, 8'h05, 8'h11, 8'h22, 8'h33, 8'h00, 8'h07, 8'h5a});
	endtask

	task automatic test_raw_and_unused_modes();
		set_mode(bmprle_pkg::MODE_RAW);
		send_list('{8'h00, 8'hff});
		set_mode(bmprle_pkg::MODE_NONE);
		send_byte(8'h01);
	endtask

	task automatic test_backpressure();
		set_mode(bmprle_pkg::MODE_RLE8);
		gap_limit = 0;
		hold_request = 1'b1;
		repeat (24) begin
			send_byte(8'($urandom_range(1, 255)));
			send_byte(8'($urandom));
		end
	endtask

	task automatic test_random_streams();
		int sent;
		int budget;
		int pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			// A held x offset is checked against the width only when its y byte arrives.
			if ($urandom_range(0, 1) == 0 && parse_phase != bmprle_pkg::PH_DY) begin
				write_register(bmprle_pkg::REG_WIDTH, pick_bound());
				write_register(bmprle_pkg::REG_HEIGHT, pick_bound());
			end
			pick = $urandom_range(0, 9);
			if (pick == 0)
				set_mode(bmprle_pkg::MODE_RAW);
			else if (pick == 1)
				set_mode(bmprle_pkg::MODE_NONE);
			else if (pick < 6)
				set_mode(bmprle_pkg::MODE_RLE8);
			else
				set_mode(bmprle_pkg::MODE_RLE4);
			case ($urandom_range(0, 2))
				0: gap_limit = 0;
				1: gap_limit = 3;
				default: gap_limit = 8;
			endcase
			budget = $urandom_range(60, 200);
			stream_bytes.delete();
			for (int k = 0; k < budget; k++) begin
				if (stream_bytes.size() == 0)
					queue_sequence();
				send_byte(stream_bytes.pop_front());
			end
			sent += budget;
		end
	endtask

	task automatic test_stop_and_after();
		logic [15:0] w;
		logic [15:0] h;
		w = 16'($urandom_range(1, 254));
		h = 16'($urandom_range(1, 254));
		set_mode(($urandom_range(0, 1) == 0) ? bmprle_pkg::MODE_RLE8 : bmprle_pkg::MODE_RLE4);
		gap_limit = 3;
		while (parse_phase != bmprle_pkg::PH_FIRST)
			send_byte(8'($urandom));
		write_register(bmprle_pkg::REG_WIDTH, w);
		write_register(bmprle_pkg::REG_HEIGHT, h);
		stop_allowed = 1'b1;
		case ($urandom_range(0, 2))
			0: send_list('{8'h00, 8'h01});
			1: send_list('{8'h00, 8'h02, 8'($urandom_range(int'(w) + 1, 255)),
				8'($urandom_range(0, int'(h)))});
			default: send_list('{8'h00, 8'h02, 8'($urandom_range(0, int'(w))),
				8'($urandom_range(int'(h) + 1, 255))});
		endcase
		repeat (12) send_byte(8'($urandom));
		set_mode(bmprle_pkg::MODE_RAW);
		repeat (8) send_byte(8'($urandom));
		set_mode(bmprle_pkg::MODE_RLE8);
		repeat (4) send_byte(8'($urandom));
		set_mode(bmprle_pkg::MODE_NONE);
		repeat (3) send_byte(8'($urandom));
	endtask

	initial begin
		reset_model();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_rle8_escapes();
		test_rle4_runs();
		test_raw_and_unused_modes();
		test_backpressure();
		test_random_streams();
		test_stop_and_after();
		await_idle();
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
